/* hdl/strm_pkg.sv */
// Shared widths, operation codes and defaults for the segment tree range max block.
package strm_pkg;

  localparam int unsigned LEAVES_DEF = 1024;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int RANGE_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QRY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

endpackage

/* hdl/segment_tree_range_max.sv */
// Range-maximum segment tree with point update, held in one synchronous memory.
// Set: write the leaf, then per level a sibling read and a parent write, up to the root.
// Query: strobe in the cycle after start when the range is empty, else a bottom-up walk;
//   at most one memory read per cycle sets the pace.
// Clear and reset both run a sweep over all 2*LEAVES node addresses, busy high.
// Reset is synchronous, active low; the receiver cannot stall, out_valid is a pulse.
module segment_tree_range_max #(
  parameter int unsigned LEAVES = strm_pkg::LEAVES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic        [strm_pkg::FUNC_W-1:0]  in_func,
  input  logic        [strm_pkg::IDX_W-1:0]   in_leaf_index,
  input  logic signed [strm_pkg::VAL_W-1:0]   in_leaf_value,
  input  logic        [strm_pkg::RANGE_W-1:0] in_range_left,
  input  logic        [strm_pkg::RANGE_W-1:0] in_range_right,
  output logic                                out_valid,
  output logic signed [strm_pkg::VAL_W-1:0]   out_range_max
);
  import strm_pkg::*;

  // Node address width: heap order, root at 1, leaf i at LEAVES+i.
  localparam int AW    = $clog2(LEAVES) + 1;
  localparam int DEPTH = 2 * LEAVES;
  // Compare width wide enough for raw range fields and for LEAVES itself.
  localparam int CW    = (AW + 1 > RANGE_W) ? AW + 1 : RANGE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLR   = 5'b00010,
    S_UP_RD = 5'b00100,
    S_UP_WR = 5'b01000,
    S_QRY   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Node memory, one read port with registered data, one write port.
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;

  // Walk state.
  logic [AW-1:0]           node_r, node_nxt;   // current node of an update walk
  logic signed [VAL_W-1:0] cur_r, cur_nxt;     // value just written at node_r
  logic [AW:0]             lo_r, lo_nxt;       // query bounds in node space
  logic [AW:0]             hi_r, hi_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;     // running maximum of a query
  logic                    pend_r, pend_nxt;   // read data due this cycle joins res
  logic [AW-1:0]           clr_r, clr_nxt;     // sweep address of a clear
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_max_r, out_max_nxt;

  // Decode of the incoming item.
  logic [CW-1:0]           left_ext;
  logic [CW-1:0]           right_cl;
  logic                    range_empty;
  logic                    leaf_ok;
  logic [AW-1:0]           leaf_node;
  logic [AW-1:0]           parent;
  logic signed [VAL_W-1:0] up_max;
  logic signed [VAL_W-1:0] merged;
  logic [AW:0]             hi_m1;

  assign left_ext    = CW'(in_range_left);
  // Clamp the exclusive end to the leaf count.
  assign right_cl    = (CW'(in_range_right) > CW'(LEAVES)) ? CW'(LEAVES)
                                                           : CW'(in_range_right);
  assign range_empty = (left_ext >= right_cl);
  // Drop a set aimed past the last leaf.
  assign leaf_ok     = (CW'(in_leaf_index) < CW'(LEAVES));
  assign leaf_node   = AW'(LEAVES) + AW'(in_leaf_index);

  assign parent = node_r >> 1;
  assign up_max = (rdata_r > cur_r) ? rdata_r : cur_r;
  assign merged = (pend_r && (rdata_r > res_r)) ? rdata_r : res_r;
  assign hi_m1  = hi_r - (AW+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    pend_nxt      = 1'b0;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_max_nxt   = out_max_r;
    raddr         = lo_r[AW-1:0];
    we            = 1'b0;
    waddr         = clr_r;
    wdata         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_func)
            FUNC_SET: begin
              // Write the leaf now, then climb one level per read/write pair.
              if (leaf_ok) begin
                we        = 1'b1;
                waddr     = leaf_node;
                wdata     = in_leaf_value;
                node_nxt  = leaf_node;
                cur_nxt   = in_leaf_value;
                state_nxt = S_UP_RD;
              end
            end
            FUNC_QRY: begin
              if (range_empty) begin
                // Nothing to visit: report the identity at once.
                out_valid_nxt = 1'b1;
                out_max_nxt   = '0;
              end else begin
                lo_nxt    = (AW+1)'(LEAVES) + (AW+1)'(left_ext);
                hi_nxt    = (AW+1)'(LEAVES) + (AW+1)'(right_cl);
                res_nxt   = '0;
                state_nxt = S_QRY;
              end
            end
            FUNC_CLR: begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: ;  // unused selector: drop the item
          endcase
        end
      end

      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_UP_RD: begin
        // Fetch the sibling; its value is not touched by this walk.
        raddr     = node_r ^ AW'(1);
        state_nxt = S_UP_WR;
      end

      S_UP_WR: begin
        we       = 1'b1;
        waddr    = parent;
        wdata    = up_max;
        cur_nxt  = up_max;
        node_nxt = parent;
        if (parent == AW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end

      S_QRY: begin
        res_nxt = merged;
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            // Left boundary is a right child: take it and step inward.
            raddr    = lo_r[AW-1:0];
            lo_nxt   = lo_r + (AW+1)'(1);
            pend_nxt = 1'b1;
          end else if (hi_r[0]) begin
            raddr    = hi_m1[AW-1:0];
            hi_nxt   = hi_m1;
            pend_nxt = 1'b1;
          end else begin
            // Both bounds even: advance one level up.
            lo_nxt = lo_r >> 1;
            hi_nxt = hi_r >> 1;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = merged;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory: synchronous read, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Control state; reset starts a clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    res_r     <= res_nxt;
    out_max_r <= out_max_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;

endmodule

/* hdl/strm_checker.sv */
// Port-level checker for the segment tree range max block, with its bind.
module strm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic        [strm_pkg::FUNC_W-1:0]  in_func,
  input logic                                out_valid,
  input logic signed [strm_pkg::VAL_W-1:0]   out_range_max
);
  import strm_pkg::*;

  // Reset always launches the clearing sweep.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // A result follows only a query transfer or work already in flight.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || ($past(start) && $past(in_func) == FUNC_QRY)))
    else $error("result strobe without a query");

  // Identity is zero, so no result is ever negative.
  a_out_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_range_max[VAL_W-1])
    else $error("negative range maximum reported");

  // A clear transfer occupies the block and yields no result.
  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_CLR) |=> (busy && !out_valid))
    else $error("clear did not start a sweep");

  // An unused selector is dropped without effect.
  a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FUNC_SET && in_func != FUNC_QRY &&
     in_func != FUNC_CLR) |=> (!busy && !out_valid))
    else $error("unused selector had an effect");

endmodule

bind segment_tree_range_max strm_checker u_strm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_range_max (out_range_max)
);

/* sim/range_max_tracker_pkg.sv */
// Scoreboard class that tracks the expected range maxima of the segment tree.
`timescale 1ns / 100ps

package range_max_tracker_pkg;
  import strm_pkg::*;

  class range_max_tracker;
    logic signed [VAL_W-1:0] node_max [2*LEAVES_DEF];
    logic signed [VAL_W-1:0] pending_max_q [$];
    int unsigned mismatches;

    function new();
      clear_tree();
      mismatches = 0;
    endfunction

    function void clear_tree();
      foreach (node_max[k]) node_max[k] = '0;
    endfunction

    function void write_leaf(int unsigned idx, logic signed [VAL_W-1:0] v);
      int unsigned p;
      if (idx >= LEAVES_DEF) return;
      p = LEAVES_DEF + idx;
      node_max[p] = v;
      p >>= 1;
      while (p >= 1) begin
        node_max[p] = (node_max[2*p] > node_max[2*p+1]) ? node_max[2*p] : node_max[2*p+1];
        p >>= 1;
      end
    endfunction

    // Bottom-up walk over [lo, hi); the running max starts at the identity 0.
    function logic signed [VAL_W-1:0] max_over_range(int unsigned lo, int unsigned hi);
      logic signed [VAL_W-1:0] best;
      int unsigned a;
      int unsigned b;
      best = '0;
      a = lo;
      b = (hi > LEAVES_DEF) ? LEAVES_DEF : hi;
      if (a >= b) return best;
      a += LEAVES_DEF;
      b += LEAVES_DEF;
      while (a < b) begin
        if (a & 1) begin
          if (node_max[a] > best) best = node_max[a];
          a++;
        end
        if (b & 1) begin
          b--;
          if (node_max[b] > best) best = node_max[b];
        end
        a >>= 1;
        b >>= 1;
      end
      return best;
    endfunction

    function void note_transfer(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                logic signed [VAL_W-1:0] v,
                                logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
      case (f)
        FUNC_SET: write_leaf(32'(idx), v);
        FUNC_QRY: pending_max_q.push_back(max_over_range(32'(lo), 32'(hi)));
        FUNC_CLR: clear_tree();
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [VAL_W-1:0] got);
      logic signed [VAL_W-1:0] want;
      if (pending_max_q.size() == 0) begin
        $display("%0t: range max %0d arrived with no query outstanding", $time, got);
        mismatches++;
      end else begin
        want = pending_max_q.pop_front();
        if (got !== want) begin
          $display("%0t: range max mismatch: expected %0d, actual %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_max_q.size();
    endfunction
  endclass

endpackage

/* sim/testbench.sv */
// Top-level testbench for the segment tree range max block.
`timescale 1ns / 100ps

module testbench;
  import strm_pkg::*;
  import range_max_tracker_pkg::*;

  localparam int unsigned LEAVES      = LEAVES_DEF;
  localparam int unsigned STALL_LIMIT = 16 * LEAVES;  // a clear sweep covers 2*LEAVES nodes
  localparam int unsigned RAND_ITEMS  = 750;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       start          = 1'b0;
  logic                       busy;
  logic        [FUNC_W-1:0]   in_func        = FUNC_SET;
  logic        [IDX_W-1:0]    in_leaf_index  = '0;
  logic signed [VAL_W-1:0]    in_leaf_value  = '0;
  logic        [RANGE_W-1:0]  in_range_left  = '0;
  logic        [RANGE_W-1:0]  in_range_right = '0;
  logic                       out_valid;
  logic signed [VAL_W-1:0]    out_range_max;

  range_max_tracker board;

  segment_tree_range_max #(.LEAVES(LEAVES)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_leaf_index (in_leaf_index),
    .in_leaf_value (in_leaf_value),
    .in_range_left (in_range_left),
    .in_range_right(in_range_right),
    .out_valid     (out_valid),
    .out_range_max (out_range_max)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check every strobed result against the oldest outstanding query.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_result(out_range_max);
  end

  // Present one command and hold it until the block takes it; the transfer
  // happens at the first edge that sees start high and busy low.
  task automatic send_op(input logic [FUNC_W-1:0] f, input int unsigned idx,
                         input int v, input int unsigned lo, input int unsigned hi);
    start          <= 1'b1;
    in_func        <= f;
    in_leaf_index  <= IDX_W'(idx);
    in_leaf_value  <= v;
    in_range_left  <= RANGE_W'(lo);
    in_range_right <= RANGE_W'(hi);
    do @(posedge clk); while (busy !== 1'b0);
    board.note_transfer(f, IDX_W'(idx), v, RANGE_W'(lo), RANGE_W'(hi));
  endtask

  // Drop start and hold off until every outstanding query has been answered.
  task automatic drain_queries();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Leaf values: favor small magnitudes so maxima compete, mixed with extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return $urandom_range(0, 1000);
    if (sel < 50) return -$signed($urandom_range(1, 1000));
    if (sel < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int unsigned win_lo;
    int unsigned win_w;
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;

    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation and the corner cases of the range logic.
    send_op(FUNC_QRY, $urandom, $urandom, 0, LEAVES);            // fresh tree reads 0
    send_op(FUNC_SET, 0, 32'sh7FFF_FFFF, $urandom, $urandom);
    send_op(FUNC_SET, LEAVES - 1, 32'sh8000_0000, $urandom, $urandom);
    send_op(FUNC_SET, 512, 5, 2047, 2047);
    send_op(FUNC_QRY, 1023, -1, 0, LEAVES);                      // whole tree
    send_op(FUNC_QRY, $urandom, $urandom, 1, LEAVES);
    send_op(FUNC_QRY, $urandom, $urandom, LEAVES - 1, LEAVES);   // negative leaf only
    send_op(FUNC_QRY, $urandom, $urandom, 1, 2047);              // end clamped to LEAVES
    send_op(FUNC_QRY, $urandom, $urandom, 2047, 2047);           // empty, both past end
    send_op(FUNC_QRY, $urandom, $urandom, LEAVES, 2047);         // empty after clamping
    send_op(FUNC_QRY, $urandom, $urandom, 600, 100);             // left above right
    send_op(FUNC_QRY, $urandom, $urandom, 512, 512);             // zero width
    send_op(FUNC_RSVD, 1023, -1, 2047, 2047);                    // unused code, no effect
    send_op(FUNC_QRY, $urandom, $urandom, 0, LEAVES);
    send_op(FUNC_SET, 0, -7, $urandom, $urandom);                // overwrite with negative
    send_op(FUNC_QRY, $urandom, $urandom, 0, 1);
    send_op(FUNC_SET, 511, 1000, $urandom, $urandom);
    send_op(FUNC_QRY, $urandom, $urandom, 511, 513);             // straddles the midpoint
    send_op(FUNC_CLR, 1023, 32'sh7FFF_FFFF, 2047, 2047);
    send_op(FUNC_QRY, $urandom, $urandom, 0, LEAVES);
    send_op(FUNC_SET, 700, 42, $urandom, $urandom);
    send_op(FUNC_QRY, $urandom, $urandom, 700, 701);
    send_op(FUNC_QRY, $urandom, $urandom, 0, 700);
    drain_queries();

    // Random: sets and queries cluster in a moving window so that queries
    // land on written leaves; clears and the unused code are rare.
    win_w  = LEAVES;
    win_lo = 0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 50 == 0) begin
        sel    = $urandom_range(0, 9);
        win_w  = (sel < 4) ? 4 : (sel < 8) ? 64 : LEAVES;
        win_lo = $urandom_range(0, LEAVES - win_w);
      end

      // Idle now and then, except for one long stretch at full rate.
      if (k == 400) begin
        drain_queries();
      end else if ((k < 300 || k >= 450) && $urandom_range(0, 99) < 14) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end

      sel = $urandom_range(0, 99);
      if (sel < 46) begin
        lo = ($urandom_range(0, 9) < 8) ? win_lo + $urandom_range(0, win_w - 1)
                                        : $urandom_range(0, LEAVES - 1);
        send_op(FUNC_SET, lo, pick_value(), $urandom, $urandom);
      end else if (sel < 94) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          lo = win_lo + $urandom_range(0, win_w - 1);
          hi = lo + $urandom_range(1, win_lo + win_w - lo);
        end else if (sel < 60) begin
          lo = win_lo + $urandom_range(0, win_w - 1);
          hi = lo + 1;
        end else if (sel < 72) begin
          hi = $urandom_range(0, LEAVES);
          lo = $urandom_range(hi, 2047);
        end else if (sel < 85) begin
          lo = $urandom_range(0, LEAVES - 1);
          hi = $urandom_range(LEAVES + 1, 2047);
        end else begin
          lo = $urandom_range(0, 2047);
          hi = $urandom_range(0, 2047);
        end
        send_op(FUNC_QRY, $urandom, $urandom, lo, hi);
      end else if (sel < 96) begin
        send_op(FUNC_CLR, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_op(FUNC_RSVD, $urandom, $urandom, $urandom, $urandom);
      end
    end

    // Let the last answers arrive, then give any sweep or walk time to finish.
    drain_queries();
    while (busy !== 1'b0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: end the run when nothing transfers for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
